[src/mpe_pkg.sv]
// Shared types and constants for the matrix product engine.
package mpe_pkg;

   // Field widths of the item channels
   localparam int CMD_W     = 2;
   localparam int IDX_W     = 5;
   localparam int VALUE_W   = 16;
   localparam int PRODUCT_W = 37;

   // Register file
   localparam int CFG_W       = 6;
   localparam int APB_ADDR_W  = 4;
   localparam int APB_DATA_W  = 32;
   localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

   localparam logic [1:0] REG_ROWS_A = 2'd0;
   localparam logic [1:0] REG_COLS_A = 2'd1;
   localparam logic [1:0] REG_COLS_B = 2'd2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WR_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WR_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic issue;
      logic load_out;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic query_ok;
      logic ca_zero;
      logic last_k;
      logic pipe_empty;
      logic out_free;
   } dp_status_type;

endpackage

[src/mpe_csr.sv]
// Size registers behind the APB-style port, with saturation to the store size.
module mpe_csr #(
   parameter int MAX_DIM = 32,
   localparam int CNT_W  = $clog2(MAX_DIM + 1),
   localparam int DW     = (CNT_W > mpe_pkg::CFG_W) ? CNT_W : mpe_pkg::CFG_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mpe_pkg::APB_ADDR_W-1:0]   paddr,
   input  logic [mpe_pkg::APB_DATA_W-1:0]   pwdata,
   output logic [mpe_pkg::APB_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [DW-1:0]                    rows_a_use,
   output logic [DW-1:0]                    cols_a_use,
   output logic [DW-1:0]                    cols_b_use
);

   logic [mpe_pkg::CFG_W-1:0] rows_a_ff, rows_a_in;
   logic [mpe_pkg::CFG_W-1:0] cols_a_ff, cols_a_in;
   logic [mpe_pkg::CFG_W-1:0] cols_b_ff, cols_b_in;
   logic                      wr_en;
   logic [1:0]                reg_sel;
   logic [mpe_pkg::CFG_W-1:0] wr_val;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];
   assign wr_val  = pwdata[mpe_pkg::CFG_W-1:0];

   always_comb begin
      rows_a_in = rows_a_ff;
      cols_a_in = cols_a_ff;
      cols_b_in = cols_b_ff;
      if (wr_en) begin
         case (reg_sel)
            mpe_pkg::REG_ROWS_A: rows_a_in = wr_val;
            mpe_pkg::REG_COLS_A: cols_a_in = wr_val;
            mpe_pkg::REG_COLS_B: cols_b_in = wr_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= mpe_pkg::CFG_RESET;
         cols_a_ff <= mpe_pkg::CFG_RESET;
         cols_b_ff <= mpe_pkg::CFG_RESET;
      end else begin
         rows_a_ff <= rows_a_in;
         cols_a_ff <= cols_a_in;
         cols_b_ff <= cols_b_in;
      end
   end

   always_comb begin
      case (reg_sel)
         mpe_pkg::REG_ROWS_A: prdata = mpe_pkg::APB_DATA_W'(rows_a_ff);
         mpe_pkg::REG_COLS_A: prdata = mpe_pkg::APB_DATA_W'(cols_a_ff);
         mpe_pkg::REG_COLS_B: prdata = mpe_pkg::APB_DATA_W'(cols_b_ff);
         default:             prdata = '0;
      endcase
   end

   // Clamp sizes above the store dimension
   assign rows_a_use = (DW'(rows_a_ff) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rows_a_ff);
   assign cols_a_use = (DW'(cols_a_ff) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cols_a_ff);
   assign cols_b_use = (DW'(cols_b_ff) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cols_b_ff);

endmodule

[src/mpe_ctrl.sv]
// Sequencing state machine for item acceptance, dot-product issue and result hand-off.
module mpe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mpe_pkg::dp_status_type dp_status,
   output mpe_pkg::ctrl_cmd_type  dp_cmd
);

   mpe_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpe_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (dp_status.query_ok && !dp_status.ca_zero) begin
                  state_in = mpe_pkg::ST_ISSUE;
               end else begin
                  state_in = mpe_pkg::ST_FINISH;
               end
            end
         end
         mpe_pkg::ST_ISSUE: begin
            if (dp_status.last_k) begin
               state_in = mpe_pkg::ST_DRAIN;
            end
         end
         mpe_pkg::ST_DRAIN: begin
            if (dp_status.pipe_empty) begin
               state_in = mpe_pkg::ST_FINISH;
            end
         end
         mpe_pkg::ST_FINISH: begin
            if (dp_status.out_free) begin
               state_in = mpe_pkg::ST_IDLE;
            end
         end
         default: state_in = mpe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_stall       = 1'b1;
      dp_cmd.accept   = 1'b0;
      dp_cmd.issue    = 1'b0;
      dp_cmd.load_out = 1'b0;
      case (state_ff)
         mpe_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            dp_cmd.accept = req_valid;
         end
         mpe_pkg::ST_ISSUE: begin
            dp_cmd.issue = 1'b1;
         end
         mpe_pkg::ST_DRAIN: ;
         mpe_pkg::ST_FINISH: begin
            dp_cmd.load_out = dp_status.out_free;
         end
         default: ;
      endcase
   end

endmodule

[src/mpe_dpath.sv]
// Element stores, multiply-accumulate pipeline and result register.
module mpe_dpath #(
   parameter int MAX_DIM    = 32,
   parameter int ELEM_WIDTH = 16,
   localparam int CNT_W     = $clog2(MAX_DIM + 1),
   localparam int DW        = (CNT_W > mpe_pkg::CFG_W) ? CNT_W : mpe_pkg::CFG_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mpe_pkg::ctrl_cmd_type               dp_cmd,
   output mpe_pkg::dp_status_type              dp_status,
   input  logic [mpe_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mpe_pkg::IDX_W-1:0]           req_row,
   input  logic [mpe_pkg::IDX_W-1:0]           req_col,
   input  logic signed [mpe_pkg::VALUE_W-1:0]  req_value,
   input  logic [DW-1:0]                       rows_a_use,
   input  logic [DW-1:0]                       cols_a_use,
   input  logic [DW-1:0]                       cols_b_use,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [mpe_pkg::PRODUCT_W-1:0] rsp_product,
   output logic                                rsp_status
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(MAX_DIM);
   localparam int PW    = 2 * ELEM_WIDTH;

   logic signed [ELEM_WIDTH-1:0] store_a_ff [DEPTH];
   logic signed [ELEM_WIDTH-1:0] store_b_ff [DEPTH];

   logic [mpe_pkg::IDX_W-1:0]      row_ff, row_in;
   logic [mpe_pkg::IDX_W-1:0]      col_ff, col_in;
   logic                           err_ff, err_in;
   logic [KW-1:0]                  k_ff, k_in;
   logic                           s1_ff, s2_ff;
   logic signed [ELEM_WIDTH-1:0]   rd_a_ff, rd_b_ff;
   logic signed [PW-1:0]           prod_ff, prod_in;
   logic signed [mpe_pkg::PRODUCT_W-1:0] acc_ff, acc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [mpe_pkg::PRODUCT_W-1:0] rsp_product_ff;
   logic                           rsp_status_ff;

   logic                  wa_ok, wb_ok, q_ok;
   logic                  we_a, we_b;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr_a, rd_addr_b;
   logic signed [ELEM_WIDTH-1:0] wr_data;

   // Range checks against the sizes in use
   assign wa_ok = (req_cmd == mpe_pkg::CMD_WR_A) && (DW'(req_row) < rows_a_use)
                  && (DW'(req_col) < cols_a_use);
   assign wb_ok = (req_cmd == mpe_pkg::CMD_WR_B) && (DW'(req_row) < cols_a_use)
                  && (DW'(req_col) < cols_b_use);
   assign q_ok  = (req_cmd == mpe_pkg::CMD_QUERY) && (DW'(req_row) < rows_a_use)
                  && (DW'(req_col) < cols_b_use);

   assign we_a    = dp_cmd.accept & wa_ok;
   assign we_b    = dp_cmd.accept & wb_ok;
   assign wr_addr = AW'(req_row) * AW'(MAX_DIM) + AW'(req_col);
   assign wr_data = ELEM_WIDTH'(req_value);

   assign rd_addr_a = AW'(row_ff) * AW'(MAX_DIM) + AW'(k_ff);
   assign rd_addr_b = AW'(k_ff) * AW'(MAX_DIM) + AW'(col_ff);

   always_ff @(posedge clock) begin
      if (we_a) begin
         store_a_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_a_ff[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         store_b_ff[wr_addr] <= wr_data;
      end
      rd_b_ff <= store_b_ff[rd_addr_b];
   end

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      err_in  = err_ff;
      k_in    = k_ff;
      acc_in  = acc_ff;
      prod_in = PW'(rd_a_ff) * PW'(rd_b_ff);
      if (dp_cmd.accept) begin
         row_in = req_row;
         col_in = req_col;
         err_in = !(wa_ok || wb_ok || q_ok);
         k_in   = '0;
         acc_in = '0;
      end else begin
         if (dp_cmd.issue) begin
            k_in = k_ff + KW'(1);
         end
         // Accumulate wraps at the result width
         if (s2_ff) begin
            acc_in = acc_ff + mpe_pkg::PRODUCT_W'(prod_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      err_ff  <= err_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      if (dp_cmd.load_out) begin
         rsp_product_ff <= acc_ff;
         rsp_status_ff  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= dp_cmd.issue;
         s2_ff        <= s1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign dp_status.query_ok   = q_ok;
   assign dp_status.ca_zero    = (cols_a_use == '0);
   assign dp_status.last_k     = (DW'(k_ff) + DW'(1) == cols_a_use);
   assign dp_status.pipe_empty = !s1_ff && !s2_ff;
   assign dp_status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = rsp_product_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

[src/matrix_product_engine_core.sv]
// A write or rejected item goes straight to the finish state, which loads its result;
// a query issues one product per column of A (cols_a clamped to MAX_DIM), then drains.
// Items are taken one at a time, the next only after a result loads; a stall delays it.
// Each store's single read port feeds one multiply-accumulate per cycle while issuing.
// Reset is synchronous: sizes return to 32 and the control clears; the element
// stores are not cleared and no clearing pass runs, so items are taken at once.
module matrix_product_engine_core #(
   parameter int MAX_DIM    = 32,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mpe_pkg::CMD_W-1:0]            req_cmd,
   input  logic [mpe_pkg::IDX_W-1:0]            req_row,
   input  logic [mpe_pkg::IDX_W-1:0]            req_col,
   input  logic signed [mpe_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mpe_pkg::PRODUCT_W-1:0] rsp_product,
   output logic                                 rsp_status,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mpe_pkg::APB_ADDR_W-1:0]       paddr,
   input  logic [mpe_pkg::APB_DATA_W-1:0]       pwdata,
   output logic [mpe_pkg::APB_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);
   localparam int DW    = (CNT_W > mpe_pkg::CFG_W) ? CNT_W : mpe_pkg::CFG_W;

   logic [DW-1:0]          rows_a_use, cols_a_use, cols_b_use;
   mpe_pkg::ctrl_cmd_type  dp_cmd;
   mpe_pkg::dp_status_type dp_status;

   mpe_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .rows_a_use (rows_a_use),
      .cols_a_use (cols_a_use),
      .cols_b_use (cols_b_use)
   );

   mpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   mpe_dpath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .req_cmd     (req_cmd),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .rows_a_use  (rows_a_use),
      .cols_a_use  (cols_a_use),
      .cols_b_use  (cols_b_use),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_product (rsp_product),
      .rsp_status  (rsp_status)
   );

endmodule

[src/mpe_checker.sv]
// Port-level checks for the matrix product engine, bound to the top level.
module mpe_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [mpe_pkg::CMD_W-1:0]            req_cmd,
   input logic [mpe_pkg::IDX_W-1:0]            req_row,
   input logic [mpe_pkg::IDX_W-1:0]            req_col,
   input logic signed [mpe_pkg::VALUE_W-1:0]   req_value,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [mpe_pkg::PRODUCT_W-1:0] rsp_product,
   input logic                                 rsp_status,
   input logic                                 psel,
   input logic                                 penable,
   input logic                                 pwrite,
   input logic [mpe_pkg::APB_ADDR_W-1:0]       paddr,
   input logic [mpe_pkg::APB_DATA_W-1:0]       pwdata,
   input logic [mpe_pkg::APB_DATA_W-1:0]       prdata,
   input logic                                 pready
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product) && $stable(rsp_status))
      else $error("stalled result changed");

   // A rejected item carries a zero product
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_product == '0)
      else $error("rejected item with non-zero product");

   // One item at a time: the input closes after each acceptance
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // A fresh result is only ever loaded while the input is closed
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a pending item");

endmodule

bind matrix_product_engine_core mpe_checker u_mpe_checker (.*);
